// ----- rtl/core/scec_pkg.sv -----
// Shared constants, types and helpers for the serial code entry checker.
package scec_pkg;

  localparam int CODE_LENGTH = 9;
  localparam int BUF_DEPTH   = 9;
  localparam int CURSOR_W    = 4;
  localparam int CHAR_W      = 8;
  localparam int CODE_LOW_W  = 64;

  localparam logic [CHAR_W-1:0] KEY_DELETE  = 8'd127;
  localparam logic [CHAR_W-1:0] KEY_CR      = 8'd13;
  localparam logic [CHAR_W-1:0] DIGIT_FIRST = 8'd48;
  localparam logic [CHAR_W-1:0] DIGIT_LAST  = 8'd57;
  localparam logic [CHAR_W-1:0] UPPER_FIRST = 8'd65;
  localparam logic [CHAR_W-1:0] UPPER_LAST  = 8'd90;
  localparam logic [CHAR_W-1:0] LOWER_FIRST = 8'd97;
  localparam logic [CHAR_W-1:0] LOWER_LAST  = 8'd122;

  typedef enum logic [1:0] {
    VERDICT_NONE = 2'd0,
    VERDICT_PASS = 2'd1,
    VERDICT_FAIL = 2'd2
  } verdict_t;

  typedef enum logic [0:0] {
    REG_CODE_LOW  = 1'b0,
    REG_CODE_LAST = 1'b1
  } reg_index_t;

  typedef logic [BUF_DEPTH-1:0][CHAR_W-1:0] code_t;

  // CR, digits and letters go into the entry buffer
  function automatic logic is_entry_char(input logic [CHAR_W-1:0] b);
    return (b == KEY_CR) ||
           (b >= DIGIT_FIRST && b <= DIGIT_LAST) ||
           (b >= UPPER_FIRST && b <= UPPER_LAST) ||
           (b >= LOWER_FIRST && b <= LOWER_LAST);
  endfunction

endpackage

// ----- rtl/core/scec_entry.sv -----
// Entry buffer, cursor and code compare for the serial code entry checker.
module scec_entry (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [7:0]                rx_byte,
  input  scec_pkg::code_t           code,
  output scec_pkg::verdict_t        verdict
);
  import scec_pkg::*;

  code_t               buffer;
  code_t               buffer_next;
  code_t               buffer_wr;
  logic [CURSOR_W-1:0] cursor;
  logic [CURSOR_W-1:0] cursor_next;
  logic [CURSOR_W-1:0] cursor_inc;
  logic                match;

  assign cursor_inc = cursor + CURSOR_W'(1);

  // byte stored at the cursor, as seen by the compare
  always_comb begin
    buffer_wr = buffer;
    if (cursor < CURSOR_W'(BUF_DEPTH)) begin
      buffer_wr[cursor] = rx_byte;
    end
  end

  always_comb begin
    match = 1'b1;
    for (int k = 0; k < BUF_DEPTH; k++) begin
      if (k < CODE_LENGTH && buffer_wr[k] != code[k]) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    buffer_next = buffer;
    cursor_next = cursor;
    verdict     = VERDICT_NONE;
    if (rx_byte == KEY_DELETE && cursor != '0) begin
      cursor_next = cursor - CURSOR_W'(1);
    end else if (is_entry_char(rx_byte)) begin
      buffer_next = buffer_wr;
      cursor_next = cursor_inc;
      if (cursor_inc >= CURSOR_W'(CODE_LENGTH) || rx_byte == KEY_CR) begin
        verdict     = match ? VERDICT_PASS : VERDICT_FAIL;
        buffer_next = '0;
        cursor_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer <= '0;
      cursor <= '0;
    end else if (step) begin
      buffer <= buffer_next;
      cursor <= cursor_next;
    end
  end

  // cursor stays inside the code between transactions
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    cursor < CURSOR_W'(CODE_LENGTH))
    else $error("cursor past code length");

  // a check leaves an empty buffer and the cursor at the start
  a_check_clears: assert property (@(posedge clk) disable iff (rst)
    step && verdict != VERDICT_NONE |=> buffer == '0 && cursor == '0)
    else $error("buffer not cleared after check");

  // delete never moves the cursor below zero and never writes
  a_delete_keeps_buffer: assert property (@(posedge clk) disable iff (rst)
    step && rx_byte == KEY_DELETE |=> $stable(buffer))
    else $error("delete changed the buffer");

endmodule

// ----- rtl/core/serial_code_entry_checker.sv -----
// Top level of the serial code entry checker: handshakes, code registers, result register.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry one received serial byte per transaction.
//   m_tvalid/m_tready/m_tdata return exactly one result per input transaction:
//   the echoed byte and a verdict (none, code correct, code wrong).
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the expected code:
//   index 0 holds characters one to eight (character one in bits 7:0),
//   index 1 holds the ninth character. Write only while the block is idle.
// Result: the result of a byte is registered and is on m_tdata in the cycle after it is accepted.
// Throughput: one byte per cycle while m_tready is high; the nine-place compare is a single
//   layer of byte equality ahead of the result register.
// Reset: clears the entry buffer, the cursor, both code registers and the
//   result valid flag m_tvalid. cfg_ready is always high.
// Stall: while m_tready is low the result register holds its transaction;
//   s_tready is high whenever the result register is empty or being drained.
module serial_code_entry_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // [7:0] rx_byte
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [15:0]                m_tdata,   // [7:0] echo_byte, [9:8] verdict, zero fill
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  scec_pkg::reg_index_t       cfg_index,
  input  logic [63:0]                cfg_data
);
  import scec_pkg::*;

  logic [CODE_LOW_W-1:0] code_low;
  logic [CHAR_W-1:0]     code_last;
  code_t                 code;
  logic                  step;
  verdict_t              verdict;
  logic [CHAR_W-1:0]     echo_byte;
  verdict_t              verdict_q;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      code_low  <= '0;
      code_last <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CODE_LOW:  code_low  <= cfg_data;
        REG_CODE_LAST: code_last <= cfg_data[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // unpack the code into one byte per place
  always_comb begin
    code = '0;
    for (int k = 0; k < BUF_DEPTH; k++) begin
      if (k < 8) begin
        code[k] = code_low[k*CHAR_W +: CHAR_W];
      end else begin
        code[k] = code_last;
      end
    end
  end

  // accept whenever the result slot is empty or draining this cycle
  assign s_tready = !m_tvalid || m_tready;
  assign step     = s_tvalid && s_tready;

  scec_entry u_entry (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (s_tdata[7:0]),
    .code    (code),
    .verdict (verdict)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      echo_byte <= s_tdata[7:0];
      verdict_q <= verdict;
    end
  end

  assign m_tdata = {6'b0, verdict_q, echo_byte};

  // every accepted byte produces a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    step |=> m_tvalid)
    else $error("accepted byte produced no result");

  // a held result is never overwritten by a new transaction
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !step)
    else $error("result overwritten while stalled");

  // the verdict field never carries the unused code
  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[9:8] != 2'd3)
    else $error("invalid verdict code");

endmodule
